// ===== sv/epcc_pkg.sv =====
// Shared types, register indexes and helper functions for the edge period code classifier.
package epcc_pkg;

  localparam int unsigned StampW  = 24;
  localparam int unsigned CapW    = 16;
  localparam int unsigned OvfW    = 8;
  localparam int unsigned EdgeW   = 16;
  localparam int unsigned MatchW  = 8;
  localparam int unsigned WinW    = 48;
  localparam int unsigned RuleW   = 32;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgW    = 48;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ALARM1_WIDTH_WINDOW = 8'd0,
    CFG_ALARM2_WIDTH_WINDOW = 8'd1,
    CFG_CODE_WIDTH_WINDOW   = 8'd2,
    CFG_ALARM1_COUNT_RULE   = 8'd3,
    CFG_ALARM2_COUNT_RULE   = 8'd4,
    CFG_CODE_COUNT_RULE     = 8'd5,
    CFG_END_GAP_TICKS       = 8'd6,
    CFG_IGNORE_EDGES        = 8'd7
  } cfg_idx_e;

  // Input command codes
  typedef enum logic {
    CMD_EDGE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [WinW-1:0]  alarm1_win;
    logic [WinW-1:0]  alarm2_win;
    logic [WinW-1:0]  code_win;
    logic [RuleW-1:0] alarm1_rule;
    logic [RuleW-1:0] alarm2_rule;
    logic [RuleW-1:0] code_rule;
    logic [OvfW-1:0]  end_gap;
    logic [OvfW-1:0]  ignore_edges;
  } cfg_t;

  typedef struct packed {
    logic [EdgeW-1:0] frame_edges;
    logic             code_hit;
    logic             alarm2_hit;
    logic             alarm1_hit;
  } result_t;

  typedef struct packed {
    logic             frame_active;
    logic [EdgeW-1:0] edge_total;
  } status_t;

  // Period inside [lo, hi], never when the stamp went backwards
  function automatic logic in_window(input logic [WinW-1:0] win,
                                     input logic [StampW-1:0] period,
                                     input logic negative);
    logic [StampW-1:0] lo;
    logic [StampW-1:0] hi;
    lo = win[StampW-1:0];
    hi = win[WinW-1:StampW];
    return !negative && (period >= lo) && (period <= hi);
  endfunction

  // Saturating 8-bit increment
  function automatic logic [MatchW-1:0] bump8(input logic [MatchW-1:0] v);
    return (v == {MatchW{1'b1}}) ? v : v + MatchW'(1);
  endfunction

  // Match count inside [min, max] and edge count below the limit
  function automatic logic rule_holds(input logic [RuleW-1:0] rule,
                                      input logic [MatchW-1:0] match_cnt,
                                      input logic [EdgeW-1:0] edges);
    logic [MatchW-1:0] mn;
    logic [MatchW-1:0] mx;
    logic [EdgeW-1:0]  lim;
    mn  = rule[7:0];
    mx  = rule[15:8];
    lim = rule[31:16];
    return (match_cnt <= mx) && (match_cnt >= mn) && (edges < lim);
  endfunction

endpackage

// ===== sv/epcc_cfg_regs.sv =====
// Configuration register file of the edge period code classifier.
module epcc_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [epcc_pkg::CfgIdxW-1:0] wr_idx_i,
  input  logic [epcc_pkg::CfgW-1:0]    wr_data_i,
  output epcc_pkg::cfg_t               cfg_o
);

  epcc_pkg::cfg_t cfg_q, cfg_d;

  // Decode the write index; indexes beyond the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      case (epcc_pkg::cfg_idx_e'(wr_idx_i))
        epcc_pkg::CFG_ALARM1_WIDTH_WINDOW: cfg_d.alarm1_win   = wr_data_i;
        epcc_pkg::CFG_ALARM2_WIDTH_WINDOW: cfg_d.alarm2_win   = wr_data_i;
        epcc_pkg::CFG_CODE_WIDTH_WINDOW:   cfg_d.code_win     = wr_data_i;
        epcc_pkg::CFG_ALARM1_COUNT_RULE:   cfg_d.alarm1_rule  = wr_data_i[31:0];
        epcc_pkg::CFG_ALARM2_COUNT_RULE:   cfg_d.alarm2_rule  = wr_data_i[31:0];
        epcc_pkg::CFG_CODE_COUNT_RULE:     cfg_d.code_rule    = wr_data_i[31:0];
        epcc_pkg::CFG_END_GAP_TICKS:       cfg_d.end_gap      = wr_data_i[7:0];
        epcc_pkg::CFG_IGNORE_EDGES:        cfg_d.ignore_edges = wr_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alarm1_win   <= '0;
      cfg_q.alarm2_win   <= '0;
      cfg_q.code_win     <= '0;
      cfg_q.alarm1_rule  <= '0;
      cfg_q.alarm2_rule  <= '0;
      cfg_q.code_rule    <= '0;
      cfg_q.end_gap      <= 8'd2;
      cfg_q.ignore_edges <= 8'd2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== sv/epcc_core.sv =====
// Frame state and period classification: one item processed per enabled cycle.
module epcc_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      cmd_i,
  input  logic [epcc_pkg::CapW-1:0] cap_i,
  input  epcc_pkg::cfg_t            cfg_i,
  output logic                      res_valid_o,
  output epcc_pkg::result_t         res_o,
  output epcc_pkg::status_t         status_o
);

  logic                        active_q, active_d;
  logic [epcc_pkg::OvfW-1:0]   ovf_q, ovf_d;
  logic [epcc_pkg::StampW-1:0] last_q, last_d;
  logic [epcc_pkg::EdgeW-1:0]  edges_q, edges_d;
  logic [epcc_pkg::MatchW-1:0] m1_q, m1_d, m2_q, m2_d, mc_q, mc_d;

  logic [epcc_pkg::StampW-1:0] stamp, period;
  logic                        negative;
  logic [epcc_pkg::EdgeW-1:0]  edges_inc;
  logic                        classify;
  logic [epcc_pkg::OvfW-1:0]   ovf_inc, gap;
  logic                        close;

  // Edge datapath: stamp, period and start-up filter
  always_comb begin
    stamp     = {ovf_q, cap_i};
    negative  = stamp < last_q;
    period    = stamp - last_q;
    edges_inc = (edges_q == {epcc_pkg::EdgeW{1'b1}}) ? edges_q
                                                      : edges_q + epcc_pkg::EdgeW'(1);
    classify  = active_q &&
                ({1'b0, edges_inc} > ({9'd0, cfg_i.ignore_edges} + 17'd1));
  end

  // Tick datapath: gap since the last edge in overflow ticks
  always_comb begin
    ovf_inc = ovf_q + epcc_pkg::OvfW'(1);
    gap     = ovf_inc - last_q[epcc_pkg::StampW-1:epcc_pkg::CapW];
    close   = active_q && (gap >= cfg_i.end_gap);
  end

  // Next state
  always_comb begin
    active_d = active_q;
    ovf_d    = ovf_q;
    last_d   = last_q;
    edges_d  = edges_q;
    m1_d     = m1_q;
    m2_d     = m2_q;
    mc_d     = mc_q;
    if (en_i) begin
      case (epcc_pkg::cmd_e'(cmd_i))
        epcc_pkg::CMD_EDGE: begin
          edges_d = edges_inc;
          last_d  = stamp;
          if (classify) begin
            if (epcc_pkg::in_window(cfg_i.alarm1_win, period, negative)) m1_d = epcc_pkg::bump8(m1_q);
            if (epcc_pkg::in_window(cfg_i.alarm2_win, period, negative)) m2_d = epcc_pkg::bump8(m2_q);
            if (epcc_pkg::in_window(cfg_i.code_win, period, negative))   mc_d = epcc_pkg::bump8(mc_q);
          end
          if (!active_q) begin
            active_d = 1'b1;
            ovf_d    = '0;
            m1_d     = '0;
            m2_d     = '0;
            mc_d     = '0;
          end
        end
        epcc_pkg::CMD_TICK: begin
          if (active_q) begin
            ovf_d = ovf_inc;
            if (close) begin
              active_d = 1'b0;
              ovf_d    = '0;
              last_d   = '0;
              edges_d  = '0;
              m1_d     = '0;
              m2_d     = '0;
              mc_d     = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      ovf_q    <= '0;
      last_q   <= '0;
      edges_q  <= '0;
      m1_q     <= '0;
      m2_q     <= '0;
      mc_q     <= '0;
    end else begin
      active_q <= active_d;
      ovf_q    <= ovf_d;
      last_q   <= last_d;
      edges_q  <= edges_d;
      m1_q     <= m1_d;
      m2_q     <= m2_d;
      mc_q     <= mc_d;
    end
  end

  // Result of a closing tick, judged on the frame's counts before clearing
  always_comb begin
    res_valid_o       = en_i && (epcc_pkg::cmd_e'(cmd_i) == epcc_pkg::CMD_TICK) && close;
    res_o.alarm1_hit  = epcc_pkg::rule_holds(cfg_i.alarm1_rule, m1_q, edges_q);
    res_o.alarm2_hit  = epcc_pkg::rule_holds(cfg_i.alarm2_rule, m2_q, edges_q);
    res_o.code_hit    = epcc_pkg::rule_holds(cfg_i.code_rule, mc_q, edges_q);
    res_o.frame_edges = edges_q;
  end

  assign status_o.frame_active = active_q;
  assign status_o.edge_total   = edges_q;

endmodule

// ===== sv/edge_period_code_classifier_unit.sv =====
// Top level of the edge period code classifier: input register, core, result register.
// Edges and overflow ticks are taken one transfer per cycle while the input side does not stall.
// Each accepted item is held in an input register, processed by the core against the frame
// state, and a closing tick places its result in the output register; one item per cycle is
// sustained while the output is not stalled. While a result waits the input register still
// takes one item, then the input side stalls; processing pauses only when the output register
// is full and the sink is not ready. Configuration writes must only be made while the block is
// idle.
module edge_period_code_classifier_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Item input
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [15:0]                  s_axis_tdata,  // [15:0] capture_time
  input  logic                         s_axis_tuser,  // [0] command
  // Result output
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [23:0]                  m_axis_tdata,  // [0] alarm1_hit, [1] alarm2_hit,
                                                      // [2] code_hit, [18:3] frame_edges
  // Configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [epcc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [epcc_pkg::CfgW-1:0]    cfg_data_i
);

  epcc_pkg::cfg_t    cfg;
  epcc_pkg::result_t res, res_q;
  epcc_pkg::status_t status;
  logic              res_valid;

  logic                      in_valid_q, in_valid_d;
  logic                      in_cmd_q;
  logic [epcc_pkg::CapW-1:0] in_cap_q;
  logic                      out_valid_q, out_valid_d;
  logic                      out_stall, proc_en;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  epcc_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i && cfg_ready_o),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // Flow control between input register and result register
  assign out_stall     = out_valid_q && !m_axis_tready;
  assign proc_en       = in_valid_q && !out_stall;
  assign s_axis_tready = !in_valid_q || !out_stall;

  // Input register
  assign in_valid_d = (s_axis_tvalid && s_axis_tready) || (in_valid_q && !proc_en);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_cmd_q <= s_axis_tuser;
      in_cap_q <= s_axis_tdata;
    end
  end

  // Frame state and classification
  epcc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (proc_en),
    .cmd_i       (in_cmd_q),
    .cap_i       (in_cap_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res),
    .status_o    (status)
  );

  // Result register
  assign out_valid_d = proc_en ? res_valid : out_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_en && res_valid) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, res_q};

  // A closed frame always holds at least its opening edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[18:3] != 16'd0))
    else $error("result reports an empty frame");

  // Idle frame state carries no edge count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !status.frame_active |-> (status.edge_total == '0))
    else $error("edge count left over outside a frame");

  // A held item with a blocked result register closes the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_stall) |-> !s_axis_tready)
    else $error("input accepted while the pipeline is full");

  // A result only appears after a tick was processed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(proc_en && in_cmd_q))
    else $error("result raised without a closing tick");

endmodule

// ===== tb/edge_period_code_classifier_unit_test.sv =====
// Self-checking testbench for the edge period code classifier: directed table, random frames.
`timescale 1ns / 1ps

module edge_period_code_classifier_unit_test;

  localparam int unsigned IdleLimit = 2000;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e          kind;
    epcc_pkg::cmd_e     cmd;
    epcc_pkg::cfg_idx_e reg_idx;
    logic [47:0]        value;
    bit                 typed;
    epcc_pkg::result_t  want;
  } dir_row_t;

  localparam epcc_pkg::result_t NoRep = '0;

  // Clock, reset and block ports
  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;  // [15:0] capture_time
  logic        s_axis_tuser = 1'b0;  // [0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;  // [0] alarm1_hit, [1] alarm2_hit, [2] code_hit, [18:3] frame_edges
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [epcc_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [epcc_pkg::CfgW-1:0]    cfg_data_i = '0;

  // Shadow of the classifier: configuration and frame state
  epcc_pkg::cfg_t shadow_cfg;
  bit          frame_open = 1'b0;
  logic [7:0]  ovf_ticks = '0;
  logic [23:0] prev_stamp = '0;
  logic [15:0] edges_seen = '0;
  logic [7:0]  hits_a1 = '0;
  logic [7:0]  hits_a2 = '0;
  logic [7:0]  hits_code = '0;

  epcc_pkg::result_t pending_reports[$];
  int unsigned fail_count = 0;
  int unsigned items_sent = 0;
  int unsigned frames_closed = 0;
  int unsigned reports_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned idle_cycles = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Directed stimulus: reset defaults, window edges, backwards stamp, overflow, zero end gap
  dir_row_t directed_rows [29] = '{
    '{ROW_ITEM, epcc_pkg::CMD_TICK, epcc_pkg::CFG_ALARM1_WIDTH_WINDOW, 48'hFFFF, 1'b0,
      NoRep},  // idle tick ignored
    '{ROW_ITEM, epcc_pkg::CMD_EDGE, epcc_pkg::CFG_ALARM1_WIDTH_WINDOW, 48'h0000, 1'b0, NoRep},
    '{ROW_ITEM, epcc_pkg::CMD_EDGE, epcc_pkg::CFG_ALARM1_WIDTH_WINDOW, 48'hFFFF, 1'b0, NoRep},
    '{ROW_ITEM, epcc_pkg::CMD_TICK, epcc_pkg::CFG_ALARM1_WIDTH_WINDOW, 48'h0000, 1'b0, NoRep},
    // reset rules have a zero edge limit: nothing holds
    '{ROW_ITEM, epcc_pkg::CMD_TICK, epcc_pkg::CFG_ALARM1_WIDTH_WINDOW, 48'h0000, 1'b1,
      '{16'd2, 1'b0, 1'b0, 1'b0}},
    '{ROW_CFG, epcc_pkg::CMD_EDGE, epcc_pkg::CFG_IGNORE_EDGES, 48'h0, 1'b0, NoRep},
    '{ROW_CFG, epcc_pkg::CMD_EDGE, epcc_pkg::CFG_END_GAP_TICKS, 48'h1, 1'b0, NoRep},
    '{ROW_CFG, epcc_pkg::CMD_EDGE, epcc_pkg::CFG_ALARM1_WIDTH_WINDOW, 48'h000020_000010, 1'b0,
      NoRep},
    '{ROW_CFG, epcc_pkg::CMD_EDGE, epcc_pkg::CFG_ALARM2_WIDTH_WINDOW, 48'h000020_000030, 1'b0,
      NoRep},  // crossed
    '{ROW_CFG, epcc_pkg::CMD_EDGE, epcc_pkg::CFG_CODE_WIDTH_WINDOW, 48'hFFFFFF_000000, 1'b0,
      NoRep},
    '{ROW_CFG, epcc_pkg::CMD_EDGE, epcc_pkg::CFG_ALARM1_COUNT_RULE, 48'hFFFF_FF01, 1'b0, NoRep},
    '{ROW_CFG, epcc_pkg::CMD_EDGE, epcc_pkg::CFG_ALARM2_COUNT_RULE, 48'hFFFF_FF00, 1'b0, NoRep},
    '{ROW_CFG, epcc_pkg::CMD_EDGE, epcc_pkg::CFG_CODE_COUNT_RULE, 48'h0000_FF00, 1'b0,
      NoRep},  // zero limit
    '{ROW_ITEM, epcc_pkg::CMD_EDGE, epcc_pkg::CFG_ALARM1_WIDTH_WINDOW, 48'h0100, 1'b0, NoRep},
    '{ROW_ITEM, epcc_pkg::CMD_EDGE, epcc_pkg::CFG_ALARM1_WIDTH_WINDOW, 48'h0118, 1'b0, NoRep},
    '{ROW_ITEM, epcc_pkg::CMD_EDGE, epcc_pkg::CFG_ALARM1_WIDTH_WINDOW, 48'h0110, 1'b0,
      NoRep},  // backwards
    '{ROW_ITEM, epcc_pkg::CMD_EDGE, epcc_pkg::CFG_ALARM1_WIDTH_WINDOW, 48'h0120, 1'b0,
      NoRep},  // low bound
    '{ROW_ITEM, epcc_pkg::CMD_EDGE, epcc_pkg::CFG_ALARM1_WIDTH_WINDOW, 48'h0140, 1'b0,
      NoRep},  // high bound
    '{ROW_ITEM, epcc_pkg::CMD_TICK, epcc_pkg::CFG_ALARM1_WIDTH_WINDOW, 48'h0000, 1'b0, NoRep},
    '{ROW_CFG, epcc_pkg::CMD_EDGE, epcc_pkg::CFG_END_GAP_TICKS, 48'h3, 1'b0, NoRep},
    '{ROW_ITEM, epcc_pkg::CMD_EDGE, epcc_pkg::CFG_ALARM1_WIDTH_WINDOW, 48'hFFF0, 1'b0, NoRep},
    '{ROW_ITEM, epcc_pkg::CMD_TICK, epcc_pkg::CFG_ALARM1_WIDTH_WINDOW, 48'h0000, 1'b0, NoRep},
    '{ROW_ITEM, epcc_pkg::CMD_EDGE, epcc_pkg::CFG_ALARM1_WIDTH_WINDOW, 48'h0008, 1'b0,
      NoRep},  // across overflow
    '{ROW_ITEM, epcc_pkg::CMD_TICK, epcc_pkg::CFG_ALARM1_WIDTH_WINDOW, 48'h0000, 1'b0, NoRep},
    '{ROW_ITEM, epcc_pkg::CMD_TICK, epcc_pkg::CFG_ALARM1_WIDTH_WINDOW, 48'h0000, 1'b0, NoRep},
    '{ROW_ITEM, epcc_pkg::CMD_TICK, epcc_pkg::CFG_ALARM1_WIDTH_WINDOW, 48'h0000, 1'b0, NoRep},
    '{ROW_CFG, epcc_pkg::CMD_EDGE, epcc_pkg::CFG_END_GAP_TICKS, 48'h0, 1'b0,
      NoRep},  // close on first tick
    '{ROW_ITEM, epcc_pkg::CMD_EDGE, epcc_pkg::CFG_ALARM1_WIDTH_WINDOW, 48'h1234, 1'b0, NoRep},
    '{ROW_ITEM, epcc_pkg::CMD_TICK, epcc_pkg::CFG_ALARM1_WIDTH_WINDOW, 48'h0000, 1'b0, NoRep}
  };

  edge_period_code_classifier_unit uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Period test against a {high, low} window; crossed bounds never match
  function automatic bit period_fits(input logic [47:0] win, input logic [23:0] period);
    return (period >= win[23:0]) && (period <= win[47:24]);
  endfunction

  function automatic logic [7:0] sat_inc8(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  // Match count within [min, max] and edge count under the limit
  function automatic bit rule_met(input logic [31:0] rule, input logic [7:0] match_cnt);
    return (match_cnt >= rule[7:0]) && (match_cnt <= rule[15:8]) &&
           (edges_seen < rule[31:16]);
  endfunction

  function automatic void apply_reg(input epcc_pkg::cfg_idx_e idx, input logic [47:0] val);
    case (idx)
      epcc_pkg::CFG_ALARM1_WIDTH_WINDOW: shadow_cfg.alarm1_win = val;
      epcc_pkg::CFG_ALARM2_WIDTH_WINDOW: shadow_cfg.alarm2_win = val;
      epcc_pkg::CFG_CODE_WIDTH_WINDOW:   shadow_cfg.code_win = val;
      epcc_pkg::CFG_ALARM1_COUNT_RULE:   shadow_cfg.alarm1_rule = val[31:0];
      epcc_pkg::CFG_ALARM2_COUNT_RULE:   shadow_cfg.alarm2_rule = val[31:0];
      epcc_pkg::CFG_CODE_COUNT_RULE:     shadow_cfg.code_rule = val[31:0];
      epcc_pkg::CFG_END_GAP_TICKS:       shadow_cfg.end_gap = val[7:0];
      epcc_pkg::CFG_IGNORE_EDGES:        shadow_cfg.ignore_edges = val[7:0];
      default: ;
    endcase
  endfunction

  // Advance the shadow by one item; returns 1 when a frame closes with a report
  function automatic bit classify_item(input epcc_pkg::cmd_e cmd, input logic [15:0] cap,
                                       output epcc_pkg::result_t rep);
    logic [23:0] stamp;
    logic [23:0] period;
    logic [7:0]  gap;
    bit          backwards;
    rep = '0;
    if (cmd == epcc_pkg::CMD_EDGE) begin
      stamp = {ovf_ticks, cap};
      backwards = stamp < prev_stamp;
      period = stamp - prev_stamp;
      if (edges_seen != 16'hFFFF) edges_seen = edges_seen + 16'd1;
      prev_stamp = stamp;
      if (frame_open && !backwards &&
          (32'(edges_seen) > 32'(shadow_cfg.ignore_edges) + 32'd1)) begin
        if (period_fits(shadow_cfg.alarm1_win, period)) hits_a1 = sat_inc8(hits_a1);
        if (period_fits(shadow_cfg.alarm2_win, period)) hits_a2 = sat_inc8(hits_a2);
        if (period_fits(shadow_cfg.code_win, period)) hits_code = sat_inc8(hits_code);
      end
      if (!frame_open) begin
        frame_open = 1'b1;
        ovf_ticks = '0;
        hits_a1 = '0;
        hits_a2 = '0;
        hits_code = '0;
      end
      return 1'b0;
    end
    // overflow tick: ignored while no frame is open
    if (!frame_open) return 1'b0;
    ovf_ticks = ovf_ticks + 8'd1;
    gap = ovf_ticks - prev_stamp[23:16];
    if (gap < shadow_cfg.end_gap) return 1'b0;
    rep.alarm1_hit = rule_met(shadow_cfg.alarm1_rule, hits_a1);
    rep.alarm2_hit = rule_met(shadow_cfg.alarm2_rule, hits_a2);
    rep.code_hit = rule_met(shadow_cfg.code_rule, hits_code);
    rep.frame_edges = edges_seen;
    frame_open = 1'b0;
    ovf_ticks = '0;
    prev_stamp = '0;
    edges_seen = '0;
    hits_a1 = '0;
    hits_a2 = '0;
    hits_code = '0;
    frames_closed++;
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    if (fail_count < 30) $display("mismatch: %s got 0x%0h expected 0x%0h", what, got, want);
    fail_count++;
  endtask

  task automatic set_traffic(input int unsigned mode);
    case (mode)
      0: begin
        send_idle_pct = 17;
        recv_idle_pct = 51;
      end
      1: begin
        send_idle_pct = 51;
        recv_idle_pct = 17;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  // One item transfer; valid stays high into the next item unless a gap is taken
  task automatic send_item(input epcc_pkg::cmd_e cmd, input logic [15:0] cap,
                           input bit use_typed = 1'b0,
                           input epcc_pkg::result_t typed_rep = '0);
    epcc_pkg::result_t rep;
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= cap;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (classify_item(cmd, cap, rep)) pending_reports.push_back(use_typed ? typed_rep : rep);
  endtask

  // Register write once the pipeline has drained
  task automatic write_reg(input epcc_pkg::cfg_idx_e idx, input logic [47:0] val);
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    apply_reg(idx, val);
    reg_writes++;
  endtask

  task automatic program_config(input logic [47:0] w1, input logic [47:0] w2,
                                input logic [47:0] w3, input logic [31:0] r1,
                                input logic [31:0] r2, input logic [31:0] r3,
                                input logic [7:0] gap, input logic [7:0] ign);
    write_reg(epcc_pkg::CFG_ALARM1_WIDTH_WINDOW, w1);
    write_reg(epcc_pkg::CFG_ALARM2_WIDTH_WINDOW, w2);
    write_reg(epcc_pkg::CFG_CODE_WIDTH_WINDOW, w3);
    write_reg(epcc_pkg::CFG_ALARM1_COUNT_RULE, 48'(r1));
    write_reg(epcc_pkg::CFG_ALARM2_COUNT_RULE, 48'(r2));
    write_reg(epcc_pkg::CFG_CODE_COUNT_RULE, 48'(r3));
    write_reg(epcc_pkg::CFG_END_GAP_TICKS, 48'(gap));
    write_reg(epcc_pkg::CFG_IGNORE_EDGES, 48'(ign));
  endtask

  // Narrow window of short periods, crossed now and then
  function automatic logic [47:0] rand_window();
    logic [23:0] lo;
    logic [23:0] hi;
    lo = 24'($urandom_range(3000, 1));
    hi = lo + 24'($urandom_range(3000, 0));
    if ($urandom_range(7, 0) == 0) return {lo, hi};
    return {hi, lo};
  endfunction

  function automatic logic [31:0] rand_rule();
    logic [7:0] mn;
    mn = 8'($urandom_range(3, 0));
    return {($urandom_range(3, 0) == 0) ? 16'hFFFF : 16'($urandom_range(30, 2)),
            mn + 8'($urandom_range(8, 0)), mn};
  endfunction

  // Period aimed mostly inside a window, sometimes at its bounds or anywhere
  function automatic logic [23:0] pick_period();
    logic [47:0] win;
    int unsigned pick;
    pick = $urandom_range(9, 0);
    case (pick)
      0, 1, 2: win = shadow_cfg.alarm1_win;
      3, 4:    win = shadow_cfg.alarm2_win;
      5, 6, 7: win = shadow_cfg.code_win;
      8:       return 24'($urandom_range(32'h2FFFF, 0));
      default: return 24'($urandom);
    endcase
    if (pick == 7) begin
      case ($urandom_range(3, 0))
        0: return win[23:0];
        1: return win[47:24];
        2: return win[23:0] - 24'd1;
        default: return win[47:24] + 24'd1;
      endcase
    end
    if (win[23:0] > win[47:24]) return 24'($urandom_range(6000, 0));
    return win[23:0] + 24'($urandom_range(32'(win[47:24] - win[23:0]), 0));
  endfunction

  // Edge a given period after the last one, preceded by the overflow ticks it needs
  task automatic send_edge_after(input logic [23:0] period, input int unsigned max_ticks);
    logic [23:0] target;
    logic [7:0]  need;
    int unsigned n;
    target = prev_stamp + period;
    need = target[23:16] - ovf_ticks;
    n = (32'(need) > max_ticks) ? max_ticks : 32'(need);
    repeat (n) send_item(epcc_pkg::CMD_TICK, 16'($urandom));
    send_item(epcc_pkg::CMD_EDGE, target[15:0]);
  endtask

  // One frame: mostly well formed edges, sometimes noise, closed by ticks
  task automatic send_frame(input int unsigned max_ticks);
    int unsigned n;
    n = $urandom_range(14, 1);
    if ($urandom_range(9, 0) == 0) begin
      repeat (n) send_item(epcc_pkg::cmd_e'($urandom_range(1, 0)), 16'($urandom));
    end else begin
      repeat (n) begin
        if ($urandom_range(9, 0) == 0) send_item(epcc_pkg::CMD_TICK, 16'($urandom));
        if ($urandom_range(11, 0) == 0)
          send_item(epcc_pkg::CMD_EDGE, prev_stamp[15:0] - 16'($urandom_range(255, 1)));
        else
          send_edge_after(pick_period(), max_ticks);
      end
    end
    while (frame_open) send_item(epcc_pkg::CMD_TICK, 16'($urandom));
    if ($urandom_range(4, 0) == 0) send_item(epcc_pkg::CMD_TICK, 16'($urandom));
  endtask

  task automatic run_phase(input int unsigned budget, input int unsigned min_frames,
                           input int unsigned max_ticks);
    int unsigned item0;
    int unsigned frame0;
    item0 = items_sent;
    frame0 = frames_closed;
    while ((items_sent - item0 < budget) || (frames_closed - frame0 < min_frames))
      send_frame(max_ticks);
  endtask

  // Report checker and output back-pressure
  always @(posedge clk_i) begin
    epcc_pkg::result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_reports.size() == 0) begin
        flag_mismatch("report with none pending", 32'(m_axis_tdata), 32'd0);
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        if (m_axis_tdata[0] != want.alarm1_hit)
          flag_mismatch("alarm1_hit", 32'(m_axis_tdata[0]), 32'(want.alarm1_hit));
        if (m_axis_tdata[1] != want.alarm2_hit)
          flag_mismatch("alarm2_hit", 32'(m_axis_tdata[1]), 32'(want.alarm2_hit));
        if (m_axis_tdata[2] != want.code_hit)
          flag_mismatch("code_hit", 32'(m_axis_tdata[2]), 32'(want.code_hit));
        if (m_axis_tdata[18:3] != want.frame_edges)
          flag_mismatch("frame_edges", 32'(m_axis_tdata[18:3]), 32'(want.frame_edges));
      end
    end
    m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no transfer for %0d cycles", IdleLimit);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    shadow_cfg = '0;
    shadow_cfg.end_gap = 8'd2;
    shadow_cfg.ignore_edges = 8'd2;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    set_traffic(0);
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
      else
        send_item(directed_rows[i].cmd, directed_rows[i].value[15:0],
                  directed_rows[i].typed, directed_rows[i].want);
    end

    // short periods, narrow windows
    program_config(rand_window(), rand_window(), rand_window(), rand_rule(), rand_rule(),
                   rand_rule(), 8'($urandom_range(3, 1)), 8'($urandom_range(3, 0)));
    run_phase(50, 3, 2);

    set_traffic(1);
    program_config(rand_window(), rand_window(), rand_window(), rand_rule(), rand_rule(),
                   rand_rule(), 8'($urandom_range(3, 1)), 8'($urandom_range(3, 0)));
    run_phase(50, 3, 3);

    // all zero windows and rules, closing on the first tick, most start-up edges
    set_traffic(2);
    program_config('0, '0, '0, '0, '0, '0, 8'h00, 8'hFF);
    run_phase(25, 3, 3);

    // arbitrary register contents
    program_config({16'($urandom), 32'($urandom)}, {16'($urandom), 32'($urandom)},
                   {16'($urandom), 32'($urandom)}, $urandom, $urandom, $urandom,
                   8'($urandom_range(4, 1)), 8'($urandom_range(255, 0)));
    run_phase(40, 3, 3);

    // one long frame, one tick per edge: overflow count wraps, match counter saturates
    program_config(48'hFFFFFF_000000, 48'h000001_000001, 48'h000002_000000, 32'hFFFF_FFFF,
                   32'hFFFF_FF00, 32'hFFFF_FFFE, 8'h03, 8'h00);
    repeat (260) send_edge_after(24'h010001, 2);
    while (frame_open) send_item(epcc_pkg::CMD_TICK, 16'($urandom));

    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("run: %0d items, %0d register writes, %0d frame reports checked",
             items_sent, reg_writes, reports_checked);
    $display("run: directed table, four random setups, one wrapping frame; %0d mismatches",
             fail_count);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/epcc_pkg.sv
sv/epcc_cfg_regs.sv
sv/epcc_core.sv
sv/edge_period_code_classifier_unit.sv
tb/edge_period_code_classifier_unit_test.sv
